// ===== design/wsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared codes, chunk tags and controller/datapath interface types for the
// WAV stream parser.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ERR_FMT_SHORT = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_BITS      = 3'd4;
    localparam logic [2:0] ERR_BYTE_RATE = 3'd5;
    localparam logic [2:0] ERR_ALIGN     = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    // four-character ids as read little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] FMT_TAG_PCM  = 16'd1;

    typedef struct packed {
        logic       push;
        logic [1:0] kind;
        logic [2:0] err;
        logic       last_chunk;
    } t_res_cmd;

    typedef struct packed {
        logic     restart;
        logic     shift;
        logic     clr_field;
        logic     inc_field;
        logic     load_left;
        logic     load_left_fmt;
        logic     dec_left;
        logic     set_pad;
        logic     clr_fmt;
        logic     fmt_store;
        logic     mul1;
        logic     mul2;
        logic     set_seen_fmt;
        logic     set_seen_data;
        t_res_cmd res_a;
        t_res_cmd res_b;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_riff;
        logic       is_wave;
        logic       is_fmt;
        logic       is_data;
        logic       lt16;
        logic       w_zero;
        logic       field_last;
        logic       fmt_last;
        logic       left_one;
        logic       left_zero;
        logic       odd;
        logic [2:0] fmt_err;
    } t_dp_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample;
        logic        last_chunk;
        logic [2:0]  err;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic        fmt_seen;
        logic        smp_seen;
        logic        last_result;
    } t_result;

endpackage
`default_nettype wire

// ===== design/wsp_out_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_out_queue
// Two-entry result queue; takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module wsp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_a,
    input  wsp_pkg::t_result  i_res_a,
    input  logic              i_push_b,
    input  wsp_pkg::t_result  i_res_b,
    output logic              o_valid,
    input  logic              i_ready,
    output wsp_pkg::t_result  o_head,
    output logic              o_room2
);
    import wsp_pkg::*;

    t_result    r_q [2];
    t_result    n_q0;
    t_result    n_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] base;
    logic [1:0] slot_b;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        base   = r_cnt - {1'b0, pop};
        slot_b = base + {1'b0, i_push_a};
        n_q0   = pop ? r_q[1] : r_q[0];
        n_q1   = r_q[1];
        if (i_push_a) begin
            if (base[0]) begin
                n_q1 = i_res_a;
            end else begin
                n_q0 = i_res_a;
            end
        end
        if (i_push_b) begin
            if (slot_b[0]) begin
                n_q1 = i_res_b;
            end else begin
                n_q0 = i_res_b;
            end
        end
        n_cnt = slot_b + {1'b0, i_push_b};
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q0;
        r_q[1] <= n_q1;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== design/wsp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_datapath
// Header word assembly, chunk byte counter, fmt field registers, the two-step
// byte rate multiply and result formatting.
// ----------------------------------------------------------------------------
module wsp_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  wsp_pkg::t_dp_cmd    i_cmd,
    output wsp_pkg::t_dp_status o_status,
    output logic                o_push_a,
    output wsp_pkg::t_result    o_res_a,
    output logic                o_push_b,
    output wsp_pkg::t_result    o_res_b
);
    import wsp_pkg::*;

    localparam logic [3:0] HDR_FIELD_LAST = 4'd3;
    localparam logic [3:0] FMT_FIELD_LAST = 4'd15;

    logic [31:0] r_chunk_len;
    logic [3:0]  r_field;
    logic [31:0] r_bytes_left;
    logic [15:0] r_tag;
    logic [15:0] r_chan;
    logic [31:0] r_rate;
    logic [31:0] r_brate;
    logic [15:0] r_align;
    logic [15:0] r_depth;
    logic [1:0]  r_seen;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [31:0] r_cd;

    logic [31:0] eff_chunk;
    logic [3:0]  eff_field;
    logic [31:0] word;
    logic [1:0]  n_seen;
    logic [31:0] prod_rc;
    logic [31:0] prod_pd;
    logic [31:0] prod_cd;

    function automatic t_result build(input t_res_cmd rc, input logic [7:0] smp,
                                      input logic [1:0] seen, input logic last_res);
        t_result r;
        r             = '0;
        r.kind        = rc.kind;
        r.last_result = last_res;
        case (rc.kind)
            KIND_SAMPLE: begin
                r.sample     = smp;
                r.last_chunk = rc.last_chunk;
            end
            KIND_FORMAT: begin
                r.channels = r_chan;
                r.rate     = r_rate;
                r.bits     = r_depth;
            end
            KIND_ERROR: begin
                r.err = rc.err;
            end
            default: begin
                r.fmt_seen = seen[0];
                r.smp_seen = seen[1];
            end
        endcase
        return r;
    endfunction

    assign eff_chunk = i_cmd.restart ? '0 : r_chunk_len;
    assign eff_field = i_cmd.restart ? '0 : r_field;
    assign word      = {i_data_byte, eff_chunk[31:8]};
    assign n_seen    = (i_cmd.restart ? 2'b00 : r_seen)
                     | {i_cmd.set_seen_data, i_cmd.set_seen_fmt};

    // 32-bit wrapping products
    assign prod_rc = r_rate * {16'd0, r_chan};
    assign prod_pd = r_p1 * {16'd0, r_depth};
    assign prod_cd = {16'd0, r_chan} * {16'd0, r_depth};

    always_comb begin
        o_status.is_riff    = (word == TAG_RIFF);
        o_status.is_wave    = (word == TAG_WAVE);
        o_status.is_fmt     = (word == TAG_FMT);
        o_status.is_data    = (word == TAG_DATA);
        o_status.lt16       = (word < FMT_BODY_LEN);
        o_status.w_zero     = (word == 32'd0);
        o_status.field_last = (eff_field == HDR_FIELD_LAST);
        o_status.fmt_last   = (eff_field == FMT_FIELD_LAST);
        o_status.left_one   = (r_bytes_left == 32'd1);
        o_status.left_zero  = (r_bytes_left == 32'd0);
        o_status.odd        = r_chunk_len[0];
        // byte rate compares after the 32-bit wrap, then the divide by 8
        if (r_tag != FMT_TAG_PCM) begin
            o_status.fmt_err = ERR_NOT_PCM;
        end else if (r_depth[2:0] != 3'd0) begin
            o_status.fmt_err = ERR_BITS;
        end else if ({3'b000, r_p2[31:3]} != r_brate) begin
            o_status.fmt_err = ERR_BYTE_RATE;
        end else if ({3'b000, r_cd[31:3]} != {16'd0, r_align}) begin
            o_status.fmt_err = ERR_ALIGN;
        end else begin
            o_status.fmt_err = ERR_NONE;
        end
    end

    assign o_push_a = i_cmd.res_a.push;
    assign o_push_b = i_cmd.res_b.push;
    assign o_res_a  = build(i_cmd.res_a, i_data_byte, n_seen, !i_cmd.res_b.push);
    assign o_res_b  = build(i_cmd.res_b, i_data_byte, n_seen, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len  <= '0;
            r_field      <= '0;
            r_bytes_left <= '0;
            r_seen       <= '0;
            r_tag        <= '0;
            r_chan       <= '0;
            r_rate       <= '0;
            r_brate      <= '0;
            r_align      <= '0;
            r_depth      <= '0;
        end else begin
            if (i_cmd.set_pad) begin
                r_chunk_len <= '0;
            end else if (i_cmd.shift) begin
                r_chunk_len <= word;
            end else if (i_cmd.restart) begin
                r_chunk_len <= '0;
            end

            if (i_cmd.clr_field) begin
                r_field <= '0;
            end else if (i_cmd.inc_field) begin
                r_field <= eff_field + 4'd1;
            end else if (i_cmd.restart) begin
                r_field <= '0;
            end

            // pad byte load wins over the decrement of the chunk's last byte
            if (i_cmd.set_pad) begin
                r_bytes_left <= 32'd1;
            end else if (i_cmd.load_left) begin
                r_bytes_left <= word;
            end else if (i_cmd.load_left_fmt) begin
                r_bytes_left <= word - FMT_BODY_LEN;
            end else if (i_cmd.dec_left) begin
                r_bytes_left <= r_bytes_left - 32'd1;
            end else if (i_cmd.restart) begin
                r_bytes_left <= '0;
            end

            r_seen <= n_seen;

            if (i_cmd.clr_fmt) begin
                r_tag   <= '0;
                r_chan  <= '0;
                r_rate  <= '0;
                r_brate <= '0;
                r_align <= '0;
                r_depth <= '0;
            end else if (i_cmd.fmt_store) begin
                unique case (eff_field[3:1]) inside
                    3'd0:       r_tag[{eff_field[0], 3'b000} +: 8] <= i_data_byte;
                    3'd1:       r_chan[{eff_field[0], 3'b000} +: 8] <= i_data_byte;
                    3'd2, 3'd3: r_rate[{eff_field[1:0], 3'b000} +: 8] <= i_data_byte;
                    3'd4, 3'd5: r_brate[{eff_field[1:0], 3'b000} +: 8] <= i_data_byte;
                    3'd6:       r_align[{eff_field[0], 3'b000} +: 8] <= i_data_byte;
                    default:    r_depth[{eff_field[0], 3'b000} +: 8] <= i_data_byte;
                endcase
            end
        end
    end

    // products: rate*channels and channels*bits, then *bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1 <= prod_rc;
            r_cd <= prod_cd;
        end
        if (i_cmd.mul2) begin
            r_p2 <= prod_pd;
        end
    end

endmodule
`default_nettype wire

// ===== design/wsp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_ctrl
// Parse phase machine and multiply/check sequencer; drives the datapath.
// ----------------------------------------------------------------------------
module wsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_start_of_file,
    input  logic                i_end_of_file,
    input  logic                i_room2,
    input  wsp_pkg::t_dp_status i_status,
    output wsp_pkg::t_dp_cmd    o_cmd
);
    import wsp_pkg::*;

    localparam logic [1:0] SEQ_IDLE  = 2'd0;
    localparam logic [1:0] SEQ_MUL1  = 2'd1;
    localparam logic [1:0] SEQ_MUL2  = 2'd2;
    localparam logic [1:0] SEQ_CHECK = 2'd3;

    localparam logic [3:0] PH_RIFF     = 4'd0;
    localparam logic [3:0] PH_RSIZE    = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_ID       = 4'd3;
    localparam logic [3:0] PH_SZ_FMT   = 4'd4;
    localparam logic [3:0] PH_SZ_DATA  = 4'd5;
    localparam logic [3:0] PH_SZ_OTHER = 4'd6;
    localparam logic [3:0] PH_FMT      = 4'd7;
    localparam logic [3:0] PH_DATA     = 4'd8;
    localparam logic [3:0] PH_SKIP     = 4'd9;

    logic [1:0] r_seq;
    logic [1:0] n_seq;
    logic [3:0] r_phase;
    logic [3:0] n_phase;
    logic       r_halted;
    logic       n_halted;
    logic       r_eof;
    logic       n_eof;
    logic       accept;
    logic       defer;
    logic [3:0] eff_phase;
    logic       eff_halted;
    t_dp_cmd    cmd;
    t_res_cmd   eof_res;

    function automatic t_res_cmd mk_res(input logic [1:0] kind, input logic [2:0] err,
                                        input logic last_chunk);
        t_res_cmd r;
        r.push       = 1'b1;
        r.kind       = kind;
        r.err        = err;
        r.last_chunk = last_chunk;
        return r;
    endfunction

    assign o_in_ready = (r_seq == SEQ_IDLE) && i_room2;
    assign accept     = i_in_valid && o_in_ready;
    assign eff_phase  = i_start_of_file ? PH_RIFF : r_phase;
    assign eff_halted = i_start_of_file ? 1'b0 : r_halted;
    assign o_cmd      = cmd;

    always_comb begin
        n_seq    = r_seq;
        n_phase  = r_phase;
        n_halted = r_halted;
        n_eof    = r_eof;
        defer    = 1'b0;
        cmd      = '0;
        eof_res  = '0;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (accept) begin
                    cmd.restart = i_start_of_file;
                    n_phase     = eff_phase;
                    n_halted    = eff_halted;
                    if (!eff_halted) begin
                        unique case (eff_phase) inside
                            PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID,
                            PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
                                cmd.shift = 1'b1;
                                if (!i_status.field_last) begin
                                    cmd.inc_field = 1'b1;
                                end else begin
                                    cmd.clr_field = 1'b1;
                                    unique case (eff_phase)
                                        PH_RIFF: begin
                                            if (!i_status.is_riff) begin
                                                cmd.res_a = mk_res(KIND_ERROR, ERR_NOT_WAVE, 1'b0);
                                                n_halted  = 1'b1;
                                            end else begin
                                                n_phase = PH_RSIZE;
                                            end
                                        end
                                        PH_RSIZE: n_phase = PH_WAVE;
                                        PH_WAVE: begin
                                            if (!i_status.is_wave) begin
                                                cmd.res_a = mk_res(KIND_ERROR, ERR_NOT_WAVE, 1'b0);
                                                n_halted  = 1'b1;
                                            end else begin
                                                n_phase = PH_ID;
                                            end
                                        end
                                        PH_ID: begin
                                            if (i_status.is_fmt) begin
                                                n_phase = PH_SZ_FMT;
                                            end else if (i_status.is_data) begin
                                                n_phase = PH_SZ_DATA;
                                            end else begin
                                                n_phase = PH_SZ_OTHER;
                                            end
                                        end
                                        PH_SZ_FMT: begin
                                            if (i_status.lt16) begin
                                                cmd.res_a = mk_res(KIND_ERROR, ERR_FMT_SHORT, 1'b0);
                                                n_halted  = 1'b1;
                                            end else begin
                                                cmd.load_left_fmt = 1'b1;
                                                cmd.clr_fmt       = 1'b1;
                                                n_phase           = PH_FMT;
                                            end
                                        end
                                        PH_SZ_DATA: begin
                                            cmd.set_seen_data = 1'b1;
                                            cmd.load_left     = 1'b1;
                                            n_phase = i_status.w_zero ? PH_ID : PH_DATA;
                                        end
                                        default: begin
                                            cmd.load_left = 1'b1;
                                            n_phase = i_status.w_zero ? PH_ID : PH_SKIP;
                                        end
                                    endcase
                                end
                            end
                            PH_FMT: begin
                                cmd.fmt_store = 1'b1;
                                if (i_status.fmt_last) begin
                                    cmd.clr_field = 1'b1;
                                    n_seq         = SEQ_MUL1;
                                    n_eof         = i_end_of_file;
                                    defer         = 1'b1;
                                end else begin
                                    cmd.inc_field = 1'b1;
                                end
                            end
                            PH_DATA, PH_SKIP: begin
                                cmd.dec_left = 1'b1;
                                if (eff_phase == PH_DATA) begin
                                    cmd.res_a = mk_res(KIND_SAMPLE, ERR_NONE,
                                                       i_status.left_one);
                                end
                                if (i_status.left_one) begin
                                    // chunk done: odd sizes skip one pad byte
                                    cmd.clr_field = 1'b1;
                                    if (i_status.odd) begin
                                        cmd.set_pad = 1'b1;
                                        n_phase     = PH_SKIP;
                                    end else begin
                                        n_phase = PH_ID;
                                    end
                                end
                            end
                            default: n_halted = 1'b1;
                        endcase

                        if (!n_halted && !defer && i_end_of_file) begin
                            if (((n_phase == PH_ID) && cmd.clr_field) || (n_phase == PH_SKIP)) begin
                                eof_res = mk_res(KIND_END, ERR_NONE, 1'b0);
                            end else begin
                                eof_res = mk_res(KIND_ERROR, ERR_TRUNCATED, 1'b0);
                            end
                            n_halted = 1'b1;
                            if (cmd.res_a.push) begin
                                cmd.res_b = eof_res;
                            end else begin
                                cmd.res_a = eof_res;
                            end
                        end
                    end
                end
            end
            SEQ_MUL1: begin
                cmd.mul1 = 1'b1;
                n_seq    = SEQ_MUL2;
            end
            SEQ_MUL2: begin
                cmd.mul2 = 1'b1;
                n_seq    = SEQ_CHECK;
            end
            SEQ_CHECK: begin
                n_seq = SEQ_IDLE;
                if (i_status.fmt_err != ERR_NONE) begin
                    cmd.res_a = mk_res(KIND_ERROR, i_status.fmt_err, 1'b0);
                    n_halted  = 1'b1;
                end else begin
                    cmd.set_seen_fmt = 1'b1;
                    cmd.res_a        = mk_res(KIND_FORMAT, ERR_NONE, 1'b0);
                    if (!i_status.left_zero) begin
                        n_phase = PH_SKIP;
                    end else if (i_status.odd) begin
                        cmd.set_pad = 1'b1;
                        n_phase     = PH_SKIP;
                    end else begin
                        n_phase = PH_ID;
                    end
                    // body ended on a boundary, so end of file here is clean
                    if (r_eof) begin
                        cmd.res_b = mk_res(KIND_END, ERR_NONE, 1'b0);
                        n_halted  = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_eof <= n_eof;
        if (!i_rst_n) begin
            r_seq    <= SEQ_IDLE;
            r_phase  <= PH_RIFF;
            r_halted <= 1'b0;
        end else begin
            r_seq    <= n_seq;
            r_phase  <= n_phase;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

// ===== design/wav_stream_parser.sv =====
`default_nettype none
// Results are registered in the output queue after a byte's transfer. The last byte of a 16-byte fmt body
// holds input while the sequencer steps MUL1 (rate*channels), MUL2 (*bits) and CHECK (compare), then pushes
// its result. Throughput: one byte per cycle otherwise, while the output queue has room.
// Up to two results per byte share a two-entry output queue; a byte is taken only
// when the queue can hold two. Reset: synchronous, active low; queue empty,
// parser waiting for a RIFF header.
// ----------------------------------------------------------------------------
// wav_stream_parser
// Byte-serial RIFF/WAVE PCM header checker and data chunk streamer.
// ----------------------------------------------------------------------------
module wav_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_sample_byte,
    output logic        o_last_of_chunk,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sampling_rate_hz,
    output logic [15:0] o_bits_per_sample,
    output logic        o_format_seen,
    output logic        o_samples_seen,
    output logic        o_last_result
);
    import wsp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    res_a;
    t_result    res_b;
    t_result    head;
    logic       push_a;
    logic       push_b;
    logic       room2;

    wsp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_of_file (i_start_of_file),
        .i_end_of_file   (i_end_of_file),
        .i_room2         (room2),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    wsp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_push_a    (push_a),
        .o_res_a     (res_a),
        .o_push_b    (push_b),
        .o_res_b     (res_b)
    );

    wsp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_res_a  (res_a),
        .i_push_b (push_b),
        .i_res_b  (res_b),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_head   (head),
        .o_room2  (room2)
    );

    assign o_result_kind      = head.kind;
    assign o_sample_byte      = head.sample;
    assign o_last_of_chunk    = head.last_chunk;
    assign o_error_code       = head.err;
    assign o_channel_count    = head.channels;
    assign o_sampling_rate_hz = head.rate;
    assign o_bits_per_sample  = head.bits;
    assign o_format_seen      = head.fmt_seen;
    assign o_samples_seen     = head.smp_seen;
    assign o_last_result      = head.last_result;

endmodule
`default_nettype wire

// ===== tb/sv/tb_wav_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_stream_parser
// Self-checking bench for the byte-serial WAV header parser. A short table of
// bytes covers the header error paths. Some rows carry their result typed in,
// and the rest are checked against a bit-accurate parse model. Random files
// follow: mostly well-formed RIFF/WAVE streams with fmt, data and unknown
// chunks, plus corrupted formats, truncations, abandoned files and noise.
// Both sides of the handshake stall in random bursts.
// ----------------------------------------------------------------------------
module tb_wav_stream_parser;
    import wsp_pkg::*;

    localparam int ITEMS    = 950;
    localparam int CALM_AT  = ITEMS - 120;
    localparam int DIR_ROWS = 24;

    typedef enum logic [3:0] {
        P_RIFF_ID, P_RIFF_SIZE, P_WAVE_ID, P_CHUNK_ID, P_FMT_SIZE,
        P_DATA_SIZE, P_OTHER_SIZE, P_FMT_BODY, P_DATA_BYTES, P_SKIP
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        logic       eof;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] err;
        logic       fs;
        logic       ss;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // "RIFX" straight after reset, no start marker
        '{8'h52, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h49, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h46, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h58, 1'b0, 1'b0, 1'b1, KIND_ERROR, ERR_NOT_WAVE, 1'b0, 1'b0},
        // halted: ignored, end marker too
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        // one-byte file
        '{8'h52, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED, 1'b0, 1'b0},
        // bare header, riff size all ones then zeros, ends on chunk boundary
        '{8'h52, 1'b1, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h49, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h46, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h46, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h57, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h56, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h45, 1'b0, 1'b1, 1'b1, KIND_END, ERR_NONE, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        // "WAVE" where RIFF belongs
        '{8'h57, 1'b1, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h41, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h56, 1'b0, 1'b0, 1'b0, KIND_SAMPLE, ERR_NONE, 1'b0, 1'b0},
        '{8'h45, 1'b0, 1'b0, 1'b1, KIND_ERROR, ERR_NOT_WAVE, 1'b0, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'd0;
    logic        in_sof = 1'b0;
    logic        in_eof = 1'b0;
    logic        out_ready = 1'b0;
    logic        quiet = 1'b0;
    int          ready_left = 0;
    int          fails = 0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_sample_byte;
    logic        o_last_of_chunk;
    logic [2:0]  o_error_code;
    logic [15:0] o_channel_count;
    logic [31:0] o_sampling_rate_hz;
    logic [15:0] o_bits_per_sample;
    logic        o_format_seen;
    logic        o_samples_seen;
    logic        o_last_result;

    // parse model state
    t_parse_phase pr_phase;
    logic [31:0]  pr_left;
    int unsigned  pr_nbyte;
    logic [31:0]  pr_word;
    logic [15:0]  pr_tag;
    logic [15:0]  pr_ch;
    logic [31:0]  pr_rate;
    logic [31:0]  pr_brate;
    logic [15:0]  pr_align;
    logic [15:0]  pr_bits;
    logic         pr_seen_fmt;
    logic         pr_seen_data;
    logic         pr_halted;

    t_result      results_due[$];
    logic [7:0]   fbytes[$];

    wav_stream_parser u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (in_byte),
        .i_start_of_file    (in_sof),
        .i_end_of_file      (in_eof),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_result_kind      (o_result_kind),
        .o_sample_byte      (o_sample_byte),
        .o_last_of_chunk    (o_last_of_chunk),
        .o_error_code       (o_error_code),
        .o_channel_count    (o_channel_count),
        .o_sampling_rate_hz (o_sampling_rate_hz),
        .o_bits_per_sample  (o_bits_per_sample),
        .o_format_seen      (o_format_seen),
        .o_samples_seen     (o_samples_seen),
        .o_last_result      (o_last_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_result make_result(logic [1:0] kind, logic [7:0] smp, logic last,
                                            logic [2:0] err, logic [15:0] ch, logic [31:0] rate,
                                            logic [15:0] bits, logic fs, logic ss);
        t_result r;
        r.kind        = kind;
        r.sample      = smp;
        r.last_chunk  = last;
        r.err         = err;
        r.channels    = ch;
        r.rate        = rate;
        r.bits        = bits;
        r.fmt_seen    = fs;
        r.smp_seen    = ss;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic t_result halt_with(logic [2:0] code);
        pr_halted = 1'b1;
        return make_result(KIND_ERROR, 8'd0, 1'b0, code, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0);
    endfunction

    function automatic logic [2:0] fmt_verdict();
        logic [31:0] prod;
        if (pr_tag != FMT_TAG_PCM) return ERR_NOT_PCM;
        if (pr_bits[2:0] != 3'd0) return ERR_BITS;
        // product wraps at 32 bits before the divide
        prod = pr_rate * {16'd0, pr_ch} * {16'd0, pr_bits};
        if (prod / 32'd8 != pr_brate) return ERR_BYTE_RATE;
        prod = {16'd0, pr_ch} * {16'd0, pr_bits};
        if (prod / 32'd8 != {16'd0, pr_align}) return ERR_ALIGN;
        return ERR_NONE;
    endfunction

    task automatic parse_restart();
        pr_phase     = P_RIFF_ID;
        pr_left      = 32'd0;
        pr_nbyte     = 0;
        pr_word      = 32'd0;
        pr_tag       = 16'd0;
        pr_ch        = 16'd0;
        pr_rate      = 32'd0;
        pr_brate     = 32'd0;
        pr_align     = 16'd0;
        pr_bits      = 16'd0;
        pr_seen_fmt  = 1'b0;
        pr_seen_data = 1'b0;
        pr_halted    = 1'b0;
    endtask

    // odd-sized chunks are followed by one pad byte
    task automatic close_chunk();
        if (pr_word[0]) begin
            pr_word  = 32'd0;
            pr_left  = 32'd1;
            pr_phase = P_SKIP;
        end else begin
            pr_phase = P_CHUNK_ID;
        end
        pr_nbyte = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sof, input logic eof);
        t_result     step_res[$];
        int unsigned idx;
        logic [2:0]  verdict;
        if (sof) parse_restart();
        if (pr_halted) return;
        if (pr_phase <= P_OTHER_SIZE) begin
            pr_word = {b, pr_word[31:8]};
            pr_nbyte++;
            if (pr_nbyte >= 4) begin
                pr_nbyte = 0;
                case (pr_phase)
                    P_RIFF_ID: begin
                        if (pr_word != TAG_RIFF) step_res.push_back(halt_with(ERR_NOT_WAVE));
                        else pr_phase = P_RIFF_SIZE;
                    end
                    P_RIFF_SIZE: begin
                        pr_phase = P_WAVE_ID;
                    end
                    P_WAVE_ID: begin
                        if (pr_word != TAG_WAVE) step_res.push_back(halt_with(ERR_NOT_WAVE));
                        else pr_phase = P_CHUNK_ID;
                    end
                    P_CHUNK_ID: begin
                        if (pr_word == TAG_FMT) pr_phase = P_FMT_SIZE;
                        else if (pr_word == TAG_DATA) pr_phase = P_DATA_SIZE;
                        else pr_phase = P_OTHER_SIZE;
                    end
                    P_FMT_SIZE: begin
                        if (pr_word < FMT_BODY_LEN) begin
                            step_res.push_back(halt_with(ERR_FMT_SHORT));
                        end else begin
                            pr_left  = pr_word - FMT_BODY_LEN;
                            pr_tag   = 16'd0;
                            pr_ch    = 16'd0;
                            pr_rate  = 32'd0;
                            pr_brate = 32'd0;
                            pr_align = 16'd0;
                            pr_bits  = 16'd0;
                            pr_phase = P_FMT_BODY;
                        end
                    end
                    P_DATA_SIZE: begin
                        pr_seen_data = 1'b1;
                        pr_left = pr_word;
                        if (pr_word == 32'd0) close_chunk();
                        else pr_phase = P_DATA_BYTES;
                    end
                    default: begin
                        pr_left = pr_word;
                        if (pr_word == 32'd0) close_chunk();
                        else pr_phase = P_SKIP;
                    end
                endcase
            end
        end else if (pr_phase == P_FMT_BODY) begin
            idx = pr_nbyte & 15;
            if (idx < 2) pr_tag[8*idx +: 8] = b;
            else if (idx < 4) pr_ch[8*(idx-2) +: 8] = b;
            else if (idx < 8) pr_rate[8*(idx-4) +: 8] = b;
            else if (idx < 12) pr_brate[8*(idx-8) +: 8] = b;
            else if (idx < 14) pr_align[8*(idx-12) +: 8] = b;
            else pr_bits[8*(idx-14) +: 8] = b;
            pr_nbyte = idx + 1;
            if (pr_nbyte >= 16) begin
                pr_nbyte = 0;
                verdict = fmt_verdict();
                if (verdict != ERR_NONE) begin
                    step_res.push_back(halt_with(verdict));
                end else begin
                    pr_seen_fmt = 1'b1;
                    step_res.push_back(make_result(KIND_FORMAT, 8'd0, 1'b0, ERR_NONE, pr_ch,
                                                   pr_rate, pr_bits, 1'b0, 1'b0));
                    if (pr_left > 32'd0) pr_phase = P_SKIP;
                    else close_chunk();
                end
            end
        end else if (pr_phase == P_DATA_BYTES) begin
            pr_left--;
            step_res.push_back(make_result(KIND_SAMPLE, b, pr_left == 32'd0, ERR_NONE, 16'd0,
                                           32'd0, 16'd0, 1'b0, 1'b0));
            if (pr_left == 32'd0) close_chunk();
        end else if (pr_phase == P_SKIP) begin
            pr_left--;
            if (pr_left == 32'd0) close_chunk();
        end else begin
            pr_halted = 1'b1;
        end

        if (!pr_halted && eof) begin
            if ((pr_phase == P_CHUNK_ID && pr_nbyte == 0) || pr_phase == P_SKIP) begin
                step_res.push_back(make_result(KIND_END, 8'd0, 1'b0, ERR_NONE, 16'd0, 32'd0,
                                               16'd0, pr_seen_fmt, pr_seen_data));
                pr_halted = 1'b1;
            end else begin
                step_res.push_back(halt_with(ERR_TRUNCATED));
            end
        end

        if (step_res.size() > 0) step_res[step_res.size()-1].last_result = 1'b1;
        foreach (step_res[k]) results_due.push_back(step_res[k]);
    endtask

    // hands one byte over and updates the model at the transfer edge
    task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof,
                             output int n_new);
        int n_before;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_sof   <= sof;
        in_eof   <= eof;
        do @(posedge i_clk); while (!o_in_ready);
        n_before = results_due.size();
        parse_byte(b, sof, eof);
        n_new = results_due.size() - n_before;
    endtask

    task automatic put_le(input logic [31:0] v, input int nb);
        for (int k = 0; k < nb; k++) fbytes.push_back(v[8*k +: 8]);
    endtask

    task automatic build_fmt_chunk(output logic ended);
        int unsigned extra;
        logic [15:0] ch, bits, align, tag;
        logic [31:0] rate, brate, prod;
        ended = 1'b0;
        put_le(TAG_FMT, 4);
        if ($urandom_range(0, 19) == 0) begin
            put_le($urandom_range(0, 15), 4);
            ended = 1'b1;
            return;
        end
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        case ($urandom_range(0, 9))
            0: begin
                ch = 16'hFFFF;
                bits = 16'd8;
            end
            1: begin
                ch = 16'd1;
                bits = 16'hFFF8;
            end
            2: begin
                ch = 16'd0;
                bits = 16'd0;
            end
            default: begin
                ch = 16'($urandom_range(1, 8));
                bits = 16'(8 * $urandom_range(1, 4));
            end
        endcase
        rate  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        prod  = rate * {16'd0, ch} * {16'd0, bits};
        brate = prod / 32'd8;
        prod  = {16'd0, ch} * {16'd0, bits};
        align = prod[18:3];
        tag   = FMT_TAG_PCM;
        case ($urandom_range(0, 15))
            0: tag = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            1: bits[2:0] = 3'($urandom_range(1, 7));
            2: brate = brate ^ (32'd1 << $urandom_range(0, 31));
            3: align = align ^ (16'd1 << $urandom_range(0, 15));
            default: ;
        endcase
        put_le(16 + extra, 4);
        put_le({16'd0, tag}, 2);
        put_le({16'd0, ch}, 2);
        put_le(rate, 4);
        put_le(brate, 4);
        put_le({16'd0, align}, 2);
        put_le({16'd0, bits}, 2);
        repeat (extra) fbytes.push_back(8'($urandom));
        if ((extra & 1) == 1) fbytes.push_back(8'($urandom));
    endtask

    // data or unknown chunk; a huge size runs off the end of the file
    task automatic build_plain_chunk(input logic [31:0] id, output logic ended);
        int unsigned len;
        ended = 1'b0;
        put_le(id, 4);
        if ($urandom_range(0, 29) == 0) begin
            put_le($urandom | 32'h0100_0000, 4);
            repeat ($urandom_range(0, 6)) fbytes.push_back(8'($urandom));
            ended = 1'b1;
        end else begin
            len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            put_le(len, 4);
            repeat (len) fbytes.push_back(8'($urandom));
            if ((len & 1) == 1) fbytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_file();
        int unsigned style, nchunks, pick;
        logic        ended;
        logic [31:0] id;
        fbytes.delete();
        style = $urandom_range(0, 99);
        if (style < 8) begin
            repeat ($urandom_range(1, 16)) fbytes.push_back(8'($urandom));
            return;
        end
        put_le((style < 12) ? $urandom : TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le((style < 15) ? $urandom : TAG_WAVE, 4);
        nchunks = $urandom_range(1, 4);
        ended = 1'b0;
        for (int c = 0; c < nchunks && !ended; c++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                build_fmt_chunk(ended);
            end else if (pick < 7) begin
                build_plain_chunk(TAG_DATA, ended);
            end else begin
                id = $urandom;
                if (id == TAG_FMT || id == TAG_DATA) id = ~id;
                build_plain_chunk(id, ended);
            end
        end
    endtask

    task automatic field_cmp(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input t_result want);
        field_cmp("result_kind", 32'(want.kind), 32'(o_result_kind));
        field_cmp("sample_byte", 32'(want.sample), 32'(o_sample_byte));
        field_cmp("last_of_chunk", 32'(want.last_chunk), 32'(o_last_of_chunk));
        field_cmp("error_code", 32'(want.err), 32'(o_error_code));
        field_cmp("channel_count", 32'(want.channels), 32'(o_channel_count));
        field_cmp("sampling_rate_hz", want.rate, o_sampling_rate_hz);
        field_cmp("bits_per_sample", 32'(want.bits), 32'(o_bits_per_sample));
        field_cmp("format_seen", 32'(want.fmt_seen), 32'(o_format_seen));
        field_cmp("samples_seen", 32'(want.smp_seen), 32'(o_samples_seen));
        field_cmp("last_result", 32'(want.last_result), 32'(o_last_result));
    endtask

    // result side: random stalls between flow bursts, steady at the end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            ready_left <= 0;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else if (ready_left == 0) begin
            if (out_ready && $urandom_range(0, 2) == 0) begin
                out_ready  <= 1'b0;
                ready_left <= $urandom_range(0, 18);
            end else begin
                out_ready  <= 1'b1;
                ready_left <= $urandom_range(1, 40);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual kind %0d", $time,
                         o_result_kind);
                fails++;
            end else begin
                check_result(results_due.pop_front());
            end
        end
    end

    initial begin
        int          n_new;
        int          sent;
        int          files;
        int unsigned keep, cut;
        logic        with_eof;
        t_result     typed_res;
        parse_restart();
        sent  = 0;
        files = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(DIR_TAB[r].b, DIR_TAB[r].sof, DIR_TAB[r].eof, n_new);
            if (DIR_TAB[r].typed) begin
                repeat (n_new) void'(results_due.pop_back());
                typed_res = make_result(DIR_TAB[r].kind, 8'd0, 1'b0, DIR_TAB[r].err, 16'd0,
                                        32'd0, 16'd0, DIR_TAB[r].fs, DIR_TAB[r].ss);
                typed_res.last_result = 1'b1;
                results_due.push_back(typed_res);
            end
        end

        while (sent < ITEMS) begin
            build_file();
            cut = $urandom_range(0, 99);
            with_eof = (cut < 85);
            if (cut >= 70 && cut < 85) begin
                keep = $urandom_range(1, fbytes.size());
                while (fbytes.size() > keep) void'(fbytes.pop_back());
            end
            for (int k = 0; k < fbytes.size(); k++) begin
                send_byte(fbytes[k], k == 0, with_eof && (k == fbytes.size() - 1), n_new);
                sent++;
                if (sent >= CALM_AT) quiet <= 1'b1;
                if (sent < CALM_AT && $urandom_range(0, 9) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
            end
            files++;
            // ignored bytes while the parser is halted
            if (with_eof && sent < CALM_AT && $urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0,
                                                        1'($urandom_range(0, 1)), n_new);
            end
            // drain before the next file
            if (sent < CALM_AT && (files == 2 || $urandom_range(0, 9) == 0)) begin
                in_valid <= 1'b0;
                do @(posedge i_clk); while (results_due.size() != 0);
            end
        end

        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb_wav_stream_parser: PASS");
        end else begin
            $display("tb_wav_stream_parser: FAIL");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("%0t: timeout, %0d results still expected", $time, results_due.size());
        $display("tb_wav_stream_parser: FAIL");
        $finish;
    end

endmodule
